// ===== rtl/sp3dh_pkg.sv =====
// Shared types and constants for the 3-D voxel histogram accumulator.
// Used by sp3dh_axis, sp3dh_store and spatial_3d_histogram_accumulator.
`default_nettype none

package sp3dh_pkg;

  // Flattened voxel index width and the deepest store it can address
  localparam int IDX_W       = 15;
  localparam int STORE_DEPTH = 32768;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z = 3'd5;

  localparam logic [31:0] SCALE_ONE = 32'h0001_0000;

  // One store entry: energy and hit totals of one voxel
  typedef struct packed {
    logic [47:0] energy;
    logic [31:0] hits;
  } voxel_t;

  // Step enables for the per-axis bin units
  typedef struct packed {
    logic diff_en;
    logic mag_en;
    logic mul_en;
  } axis_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG,
    ST_MUL,
    ST_INDEX,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/sp3dh_axis.sv =====
// Bin unit for one axis: difference, magnitude, Q32.32 product, floor and range test.
// Depends on sp3dh_pkg (axis_ctl_t).
`default_nettype none

module sp3dh_axis #(
  parameter int NBINS = 32
) (
  input  wire logic                  clk,
  input  wire sp3dh_pkg::axis_ctl_t  ctl,
  input  wire logic signed [31:0]    pos,
  input  wire logic signed [31:0]    low,
  input  wire logic [31:0]           scale,
  output logic [((NBINS > 1) ? $clog2(NBINS) : 1)-1:0] bin,
  output logic                       ok
);
  import sp3dh_pkg::*;

  localparam int BIN_W = (NBINS > 1) ? $clog2(NBINS) : 1;

  logic [32:0] diff;
  logic [32:0] diff_neg;
  logic        neg;
  logic [31:0] mag;
  logic [63:0] prod;
  logic [31:0] prod_hi;

  assign diff_neg = ~diff + 33'd1;
  assign prod     = 64'(mag) * 64'(scale);

  always_ff @(posedge clk) begin
    if (ctl.diff_en) begin
      diff <= {pos[31], pos} - {low[31], low};
    end
    // |diff| stays below 2^32, so 32 bits hold the magnitude
    if (ctl.mag_en) begin
      neg <= diff[32];
      mag <= diff[32] ? diff_neg[31:0] : diff[31:0];
    end
    if (ctl.mul_en) begin
      prod_hi <= prod[63:32];
    end
  end

  // Negative side lands in bin 0 only when the product vanishes (zero scale)
  always_comb begin
    if (neg) begin
      ok  = (scale == 32'd0);
      bin = '0;
    end else begin
      ok  = (prod_hi < 32'(NBINS));
      bin = prod_hi[BIN_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sp3dh_store.sv =====
// Voxel store: one synchronous memory of energy/hit totals with a clearing pass after reset.
// Depends on sp3dh_pkg (voxel_t, IDX_W).
`default_nettype none

module sp3dh_store #(
  parameter int DEPTH = 32768
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        rd_en,
  input  wire logic [sp3dh_pkg::IDX_W-1:0] rd_addr,
  output sp3dh_pkg::voxel_t                rd_data,
  input  wire logic                        wr_en,
  input  wire logic [sp3dh_pkg::IDX_W-1:0] wr_addr,
  input  wire sp3dh_pkg::voxel_t           wr_data,
  output logic                             clear_busy
);
  import sp3dh_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  voxel_t            mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr;

  // Sweep every entry to zero, one per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clr_addr   <= '0;
    end else if (clear_busy) begin
      if (clr_addr == LAST_ADDR) begin
        clear_busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear_busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr[ADDR_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr[ADDR_W-1:0]];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/spatial_3d_histogram_accumulator.sv =====
// Top level of the 3-D voxel histogram accumulator: sequencer, index math, update, output.
// Depends on sp3dh_pkg, sp3dh_axis and sp3dh_store.
`default_nettype none

// Voxel histogram over a BINS_X x BINS_Y x BINS_Z grid. An add request (mode 0)
// bins a signed Q15.16 point per axis as floor((pos - low) * scale), scale being
// the unsigned Q16.16 reciprocal bin width, and adds deposit and hits to that
// voxel with saturation (48-bit energy, 32-bit hits); the new totals come back.
// A point off the grid returns in_range 0 and all-zero fields. A read request
// (mode 1) returns the totals at read_index, or in_range 0 with zero sums when the
// index lies beyond the grid. Every request gives exactly one result.
// Timing: after reset the store is swept to zero, one entry per cycle, with
// req_stall high; configuration writes are taken during the sweep. Items are
// handled one at a time by a state sequencer around the single voxel memory:
// an add request passes through difference, magnitude, 32x32 multiply, index,
// memory read, and update and write back; a read request only through memory
// read and update. The result sits in an output register, so the next request
// is taken while a result still waits on res_stall; only the final update step
// holds until that register is free.
// Write configuration only while no request is outstanding.
module spatial_3d_histogram_accumulator #(
  parameter int BINS_X = 32,
  parameter int BINS_Y = 32,
  parameter int BINS_Z = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [sp3dh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                     cfg_data,
  // Request channel
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire logic                            mode,
  input  wire logic signed [31:0]              pos_x,
  input  wire logic signed [31:0]              pos_y,
  input  wire logic signed [31:0]              pos_z,
  input  wire logic [31:0]                     deposit,
  input  wire logic [7:0]                      hits,
  input  wire logic [sp3dh_pkg::IDX_W-1:0]     read_index,
  // Result channel
  output logic                                 res_valid,
  input  wire logic                            res_stall,
  output logic                                 in_range,
  output logic [sp3dh_pkg::IDX_W-1:0]          voxel_index,
  output logic [47:0]                          energy_sum,
  output logic [31:0]                          hit_total
);
  import sp3dh_pkg::*;

  localparam int TOTAL = BINS_X * BINS_Y * BINS_Z;
  localparam int DEPTH = (TOTAL < STORE_DEPTH) ? TOTAL : STORE_DEPTH;
  localparam int BW_X  = (BINS_X > 1) ? $clog2(BINS_X) : 1;
  localparam int BW_Y  = (BINS_Y > 1) ? $clog2(BINS_Y) : 1;
  localparam int BW_Z  = (BINS_Z > 1) ? $clog2(BINS_Z) : 1;

  // Configuration registers
  logic signed [31:0] low_x, low_y, low_z;
  logic [31:0]        scale_x, scale_y, scale_z;

  // Sequencer
  state_t    state, state_next;
  axis_ctl_t axis_ctl;
  logic      accept;
  logic      go;
  logic      rd_en;
  logic      wr_en;

  // Item held while it is in flight
  logic             item_mode;
  logic             item_ok;
  logic [IDX_W-1:0] item_addr;
  logic [31:0]      item_deposit;
  logic [7:0]       item_hits;

  // Bin and index math
  logic [BW_X-1:0] bin_x;
  logic [BW_Y-1:0] bin_y;
  logic [BW_Z-1:0] bin_z;
  logic            ok_x, ok_y, ok_z;
  logic [31:0]     idx_full;
  logic            add_ok;
  logic            read_ok;

  // Store and update
  logic   clear_busy;
  voxel_t rd_data;
  voxel_t upd;
  logic [48:0] energy_add;
  logic [32:0] hits_add;
  logic        res_in_range;
  logic [IDX_W-1:0] res_index;
  voxel_t      res_data;

  // --------------------------------------------------------------------------
  // Configuration: indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      low_x   <= '0;
      low_y   <= '0;
      low_z   <= '0;
      scale_x <= SCALE_ONE;
      scale_y <= SCALE_ONE;
      scale_z <= SCALE_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOW_X:   low_x   <= cfg_data;
        CFG_LOW_Y:   low_y   <= cfg_data;
        CFG_LOW_Z:   low_z   <= cfg_data;
        CFG_SCALE_X: scale_x <= cfg_data;
        CFG_SCALE_Y: scale_y <= cfg_data;
        CFG_SCALE_Z: scale_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Per-axis bin units; the difference is taken straight from the request ports
  sp3dh_axis #(.NBINS(BINS_X)) u_axis_x (
    .clk(clk), .ctl(axis_ctl), .pos(pos_x), .low(low_x), .scale(scale_x),
    .bin(bin_x), .ok(ok_x)
  );
  sp3dh_axis #(.NBINS(BINS_Y)) u_axis_y (
    .clk(clk), .ctl(axis_ctl), .pos(pos_y), .low(low_y), .scale(scale_y),
    .bin(bin_y), .ok(ok_y)
  );
  sp3dh_axis #(.NBINS(BINS_Z)) u_axis_z (
    .clk(clk), .ctl(axis_ctl), .pos(pos_z), .low(low_z), .scale(scale_z),
    .bin(bin_z), .ok(ok_z)
  );

  // Flatten (i*BINS_Y + j)*BINS_Z + k; constant multipliers on narrow bins
  assign idx_full = (32'(bin_x) * 32'(BINS_Y) + 32'(bin_y)) * 32'(BINS_Z) + 32'(bin_z);
  assign add_ok   = ok_x && ok_y && ok_z && (idx_full < 32'(DEPTH));
  assign read_ok  = (32'(read_index) < 32'(TOTAL));

  // --------------------------------------------------------------------------
  // Sequencer: next state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = mode ? ST_LOOKUP : ST_MAG;
        end
      end
      ST_MAG:    state_next = ST_MUL;
      ST_MUL:    state_next = ST_INDEX;
      ST_INDEX:  state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (go) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    req_stall        = (state != ST_IDLE) || clear_busy;
    accept           = req_valid && !req_stall;
    axis_ctl.diff_en = accept;
    axis_ctl.mag_en  = (state == ST_MAG);
    axis_ctl.mul_en  = (state == ST_MUL);
    rd_en            = (state == ST_LOOKUP) && item_ok;
    go               = (state == ST_UPDATE) && (!res_valid || !res_stall);
    wr_en            = go && item_ok && !item_mode;
  end

  // --------------------------------------------------------------------------
  // Item registers: capture the request, then the resolved voxel for an add
  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode    <= mode;
      item_deposit <= deposit;
      item_hits    <= hits;
      if (mode) begin
        item_addr <= read_index;
        item_ok   <= read_ok;
      end
    end else if (state == ST_INDEX) begin
      item_addr <= add_ok ? idx_full[IDX_W-1:0] : '0;
      item_ok   <= add_ok;
    end
  end

  sp3dh_store #(.DEPTH(DEPTH)) u_store (
    .clk(clk), .rst(rst),
    .rd_en(rd_en), .rd_addr(item_addr), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(item_addr), .wr_data(upd),
    .clear_busy(clear_busy)
  );

  // --------------------------------------------------------------------------
  // Saturating update; read data holds while the update step waits
  always_comb begin
    energy_add = {1'b0, rd_data.energy} + 49'(item_deposit);
    hits_add   = {1'b0, rd_data.hits} + 33'(item_hits);
    upd.energy = energy_add[48] ? '1 : energy_add[47:0];
    upd.hits   = hits_add[32] ? '1 : hits_add[31:0];

    res_in_range = item_ok;
    res_index    = item_addr;
    if (!item_ok) begin
      res_data = '0;
    end else if (item_mode) begin
      res_data = rd_data;
    end else begin
      res_data = upd;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      in_range    <= res_in_range;
      voxel_index <= res_index;
      energy_sum  <= res_data.energy;
      hit_total   <= res_data.hits;
    end
  end

  // --------------------------------------------------------------------------
  // No request may be in flight while the store is being cleared
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> (state == ST_IDLE))
    else $error("request in flight during store clear");

  // The memory read always lands in the update step
  a_lookup_update: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP) |=> (state == ST_UPDATE))
    else $error("lookup not followed by update");

  // A new result appears only out of the update step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_UPDATE))
    else $error("result raised outside update");

  // A saturating add never lowers the stored totals
  a_monotonic: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (energy_sum >= $past(rd_data.energy)) && (hit_total >= $past(rd_data.hits)))
    else $error("voxel total decreased on add");

endmodule

`default_nettype wire
